// ----- hdl/crc_checked_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ccfd_pkg.sv -----
// Types, constants and CRC step functions for the frame deframer.
// No dependencies; used by crc_checked_frame_deframer.
`timescale 1ns / 1ps

package ccfd_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int HDR_BYTES       = 5;
    localparam int CMD_BYTES       = 2;
    localparam int CRC_BYTES       = 2;
    localparam int OVERHEAD        = HDR_BYTES + CMD_BYTES + CRC_BYTES;

    localparam int POS_W  = 10;
    localparam int TOT_W  = POS_W + 1;
    localparam int MAXL_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_OUT_W = 64;
    localparam int TUSER_OUT_W = 6;

    localparam logic [7:0]  RST_START_BYTE = 8'hA5;
    localparam logic [9:0]  RST_MAX_LEN    = 10'd1015;
    localparam logic [7:0]  RST_CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  RST_CRC8_POLY  = 8'h8C;
    localparam logic [15:0] RST_CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] RST_CRC16_POLY = 16'h8408;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 3'd0,
        CFG_MAX_LEN    = 3'd1,
        CFG_CRC8_INIT  = 3'd2,
        CFG_CRC8_POLY  = 3'd3,
        CFG_CRC16_INIT = 3'd4,
        CFG_CRC16_POLY = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_LEN_LO = 3'd1,
        ST_LEN_HI = 3'd2,
        ST_SEQ    = 3'd3,
        ST_HCRC   = 3'd4,
        ST_BODY   = 3'd5
    } t_step;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_HEADER = 3'd1,
        KIND_CMD    = 3'd2,
        KIND_DATA   = 3'd3,
        KIND_CRC    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_LEN_BIG = 3'd1,
        EV_HDR_ERR = 3'd2,
        EV_GOOD    = 3'd3,
        EV_CRC_ERR = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]       seq;
        logic [15:0]      len;
        logic [15:0]      cmd;
        logic             fend;
        t_event           ev;
        logic [POS_W-1:0] pos;
        t_kind            kind;
        logic [7:0]       data;
    } t_result;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/crc_checked_frame_deframer.sv -----
// Byte-stream frame deframer: start-byte hunt, header CRC-8, whole-frame CRC-16.
// Depends on ccfd_pkg and crc_checked_frame_deframer_defines.svh.
//
// Results are registered; one byte per cycle while the output is not stalled.
// The parse state and both CRCs update in the cycle of the input transfer.
// A two-entry output stage (result register plus skid register) keeps input
// ready registered. Synchronous active-low reset restores register defaults,
// empties the output stage and returns the parser to the start-byte hunt.
`timescale 1ns / 1ps
`include "crc_checked_frame_deframer_defines.svh"

module crc_checked_frame_deframer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ccfd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ccfd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] rx_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] out_byte, [17:8] byte_position, [33:18] command_id,
    // [49:34] payload_length, [57:50] sequence_number, [63:58] zero
    output logic [ccfd_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
    // [2:0] byte_kind, [5:3] frame_event
    output logic [ccfd_pkg::TUSER_OUT_W-1:0]      m_axis_tuser,
    output logic                                  m_axis_tlast   // frame_end
);

    logic [7:0]                    r_start;
    logic [ccfd_pkg::MAXL_W-1:0]   r_max_len;
    logic [7:0]                    r_crc8_init;
    logic [7:0]                    r_crc8_poly;
    logic [15:0]                   r_crc16_init;
    logic [15:0]                   r_crc16_poly;

    ccfd_pkg::t_step               r_step, n_step;
    logic [ccfd_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [15:0]                   r_len, n_len;
    logic [7:0]                    r_hcrc, n_hcrc;
    logic [15:0]                   r_fcrc, n_fcrc;
    logic [7:0]                    r_seq, n_seq;
    logic [15:0]                   r_cmd, n_cmd;

    ccfd_pkg::t_result             n_res;
    ccfd_pkg::t_result             r_out, r_skid;
    logic                          r_out_vld, r_skid_vld, n_skid_vld;
    logic                          r_in_ready;

    logic                          acc, take;
    logic [7:0]                    b;
    logic [15:0]                   len_full;
    logic                          len_ok;
    logic [ccfd_pkg::TOT_W-1:0]    pos_ext, pos_p2, total, data_end;
    logic                          body_last;
    logic [7:0]                    hcrc_step;
    logic [15:0]                   fcrc_step;

    function automatic logic [ccfd_pkg::TOT_W-1:0] TOT_W_C(input int v);
        return ccfd_pkg::TOT_W'(v);
    endfunction

    assign b    = s_axis_tdata;
    assign acc  = s_axis_tvalid && r_in_ready;
    assign take = r_out_vld && m_axis_tready;

    assign len_full  = {b, r_len[7:0]};
    assign len_ok    = (len_full < {6'd0, r_max_len}) &&
                       (({1'b0, len_full} + 17'(ccfd_pkg::OVERHEAD))
                        <= 17'(ccfd_pkg::MAX_FRAME_BYTES));
    assign pos_ext   = {1'b0, r_pos};
    assign pos_p2    = pos_ext + TOT_W_C(ccfd_pkg::CRC_BYTES);
    assign total     = TOT_W_C(ccfd_pkg::OVERHEAD) + {1'b0, r_len[ccfd_pkg::POS_W-1:0]};
    assign data_end  = TOT_W_C(ccfd_pkg::HDR_BYTES + ccfd_pkg::CMD_BYTES)
                       + {1'b0, r_len[ccfd_pkg::POS_W-1:0]};
    assign body_last = !(pos_p2 <= total);
    assign hcrc_step = ccfd_pkg::crc8_next(r_hcrc, b, r_crc8_poly);
    assign fcrc_step = ccfd_pkg::crc16_next(r_fcrc, b, r_crc16_poly);

    // next parse step
    always_comb begin
        unique case (r_step)
            ccfd_pkg::ST_HUNT:   n_step = (b == r_start) ? ccfd_pkg::ST_LEN_LO : ccfd_pkg::ST_HUNT;
            ccfd_pkg::ST_LEN_LO: n_step = ccfd_pkg::ST_LEN_HI;
            ccfd_pkg::ST_LEN_HI: n_step = len_ok ? ccfd_pkg::ST_SEQ : ccfd_pkg::ST_HUNT;
            ccfd_pkg::ST_SEQ:    n_step = ccfd_pkg::ST_HCRC;
            ccfd_pkg::ST_HCRC:   n_step = (r_hcrc == b) ? ccfd_pkg::ST_BODY : ccfd_pkg::ST_HUNT;
            ccfd_pkg::ST_BODY:   n_step = body_last ? ccfd_pkg::ST_HUNT : ccfd_pkg::ST_BODY;
            default:             n_step = ccfd_pkg::ST_HUNT;
        endcase
    end

    // per-byte data path and result
    always_comb begin
        n_pos  = '0;
        n_len  = r_len;
        n_hcrc = r_hcrc;
        n_fcrc = r_fcrc;
        n_seq  = r_seq;
        n_cmd  = r_cmd;
        n_res.data = b;
        n_res.kind = ccfd_pkg::KIND_NONE;
        n_res.pos  = '0;
        n_res.ev   = ccfd_pkg::EV_NONE;
        n_res.fend = 1'b0;
        unique case (r_step)
            ccfd_pkg::ST_HUNT: begin
                if (b == r_start) begin
                    n_len  = '0;
                    n_seq  = '0;
                    n_cmd  = '0;
                    n_hcrc = ccfd_pkg::crc8_next(r_crc8_init, b, r_crc8_poly);
                    n_fcrc = ccfd_pkg::crc16_next(r_crc16_init, b, r_crc16_poly);
                    n_res.kind = ccfd_pkg::KIND_HEADER;
                    n_pos  = ccfd_pkg::POS_W'(1);
                end
            end
            ccfd_pkg::ST_LEN_LO, ccfd_pkg::ST_LEN_HI, ccfd_pkg::ST_SEQ: begin
                n_res.kind = ccfd_pkg::KIND_HEADER;
                n_res.pos  = r_pos;
                n_hcrc = hcrc_step;
                n_fcrc = fcrc_step;
                n_pos  = r_pos + 1'b1;
                if (r_step == ccfd_pkg::ST_LEN_LO) begin
                    n_len = {8'h00, b};
                end else if (r_step == ccfd_pkg::ST_LEN_HI) begin
                    n_len = len_full;
                    if (!len_ok) begin
                        n_res.ev   = ccfd_pkg::EV_LEN_BIG;
                        n_res.fend = 1'b1;
                        n_pos      = '0;
                    end
                end else begin
                    n_seq = b;
                end
            end
            ccfd_pkg::ST_HCRC: begin
                n_res.kind = ccfd_pkg::KIND_HEADER;
                n_res.pos  = r_pos;
                if (r_hcrc == b) begin
                    n_fcrc = fcrc_step;
                    n_pos  = r_pos + 1'b1;
                end else begin
                    n_res.ev   = ccfd_pkg::EV_HDR_ERR;
                    n_res.fend = 1'b1;
                end
            end
            ccfd_pkg::ST_BODY: begin
                n_res.pos = r_pos;
                if (pos_ext < TOT_W_C(ccfd_pkg::HDR_BYTES + ccfd_pkg::CMD_BYTES)) begin
                    n_res.kind = ccfd_pkg::KIND_CMD;
                    if (pos_ext == TOT_W_C(ccfd_pkg::HDR_BYTES)) begin
                        n_cmd = {8'h00, b};
                    end else begin
                        n_cmd = {b, r_cmd[7:0]};
                    end
                end else if (pos_ext < data_end) begin
                    n_res.kind = ccfd_pkg::KIND_DATA;
                end else begin
                    n_res.kind = ccfd_pkg::KIND_CRC;
                end
                priority if (pos_p2 < total) begin
                    n_fcrc = fcrc_step;
                    n_pos  = r_pos + 1'b1;
                end else if (pos_p2 == total) begin
                    n_fcrc = r_fcrc ^ {8'h00, b};
                    n_pos  = r_pos + 1'b1;
                end else begin
                    n_res.ev   = (r_fcrc[7:0] == 8'h00 && r_fcrc[15:8] == b) ?
                                 ccfd_pkg::EV_GOOD : ccfd_pkg::EV_CRC_ERR;
                    n_res.fend = 1'b1;
                end
            end
            default: begin
                n_pos = '0;
            end
        endcase
        n_res.cmd = n_cmd;
        n_res.len = n_len;
        n_res.seq = n_seq;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= ccfd_pkg::RST_START_BYTE;
            r_max_len    <= ccfd_pkg::RST_MAX_LEN;
            r_crc8_init  <= ccfd_pkg::RST_CRC8_INIT;
            r_crc8_poly  <= ccfd_pkg::RST_CRC8_POLY;
            r_crc16_init <= ccfd_pkg::RST_CRC16_INIT;
            r_crc16_poly <= ccfd_pkg::RST_CRC16_POLY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccfd_pkg::CFG_START_BYTE: r_start      <= i_cfg_data[7:0];
                ccfd_pkg::CFG_MAX_LEN:    r_max_len    <= i_cfg_data[ccfd_pkg::MAXL_W-1:0];
                ccfd_pkg::CFG_CRC8_INIT:  r_crc8_init  <= i_cfg_data[7:0];
                ccfd_pkg::CFG_CRC8_POLY:  r_crc8_poly  <= i_cfg_data[7:0];
                ccfd_pkg::CFG_CRC16_INIT: r_crc16_init <= i_cfg_data;
                ccfd_pkg::CFG_CRC16_POLY: r_crc16_poly <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state, advance on input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ccfd_pkg::ST_HUNT;
            r_pos  <= '0;
            r_len  <= '0;
            r_hcrc <= ccfd_pkg::RST_CRC8_INIT;
            r_fcrc <= ccfd_pkg::RST_CRC16_INIT;
            r_seq  <= '0;
            r_cmd  <= '0;
        end else if (acc) begin
            r_step <= n_step;
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_hcrc <= n_hcrc;
            r_fcrc <= n_fcrc;
            r_seq  <= n_seq;
            r_cmd  <= n_cmd;
        end
    end

    // output stage: result register plus skid register
    always_comb begin
        n_skid_vld = r_skid_vld;
        if (take || !r_out_vld) begin
            n_skid_vld = 1'b0;
        end else if (acc) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
            r_in_ready <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
            r_in_ready <= !n_skid_vld;
            if (take || !r_out_vld) begin
                r_out_vld <= r_skid_vld || acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (acc) begin
                r_out <= n_res;
            end
        end else if (acc) begin
            r_skid <= n_res;
        end
    end

    assign s_axis_tready = r_in_ready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.seq, r_out.len, r_out.cmd, r_out.pos, r_out.data};
    assign m_axis_tuser  = {r_out.ev, r_out.kind};
    assign m_axis_tlast  = r_out.fend;

    `CCFD_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid holds data with empty output")
    `CCFD_ASSERT_NOW(a_hunt_pos_zero, r_step == ccfd_pkg::ST_HUNT, r_pos == '0, "hunt with nonzero position")
    `CCFD_ASSERT_NOW(a_last_has_event, r_out_vld, r_out.fend == (r_out.ev != ccfd_pkg::EV_NONE), "frame end without event")
    `CCFD_ASSERT_NOW(a_none_pos_zero, r_out_vld && r_out.kind == ccfd_pkg::KIND_NONE, r_out.pos == '0, "outside byte with position")
    `CCFD_ASSERT_NEXT(a_stay_hunting, acc && r_step == ccfd_pkg::ST_HUNT && b != r_start, r_step == ccfd_pkg::ST_HUNT, "left hunt without start byte")

endmodule
